@@ rtl/idr_pkg.sv @@
// package for the inertial dead reckoning block: types, constants, sine rom
// no dependencies; used by every module under rtl but idr_checker
`default_nettype none

package idr_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;                 // power of two, 64 to 4096
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
   localparam int SINE_K_W         = SINE_IDX_W - 1;       // holds 0 .. quarter inclusive

   localparam logic [23:0] GRAVITY_RESET = 24'd642689;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   typedef logic [14:0] sine_rom_type [SINE_QUARTER+1];

   // quarter wave of sine magnitudes, unsigned q0.15, folded taylor series
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned frac;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned f;
      longint unsigned r;
      longint unsigned q;
      for (int k = 0; k <= SINE_QUARTER; k++) begin
         frac = longint'(k) << (32 - SINE_IDX_W);
         x  = (frac * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         f  = ONE_Q30 - x2 / 110;
         f  = ONE_Q30 - ((x2 * f) >> 30) / 72;
         f  = ONE_Q30 - ((x2 * f) >> 30) / 42;
         f  = ONE_Q30 - ((x2 * f) >> 30) / 20;
         f  = ONE_Q30 - ((x2 * f) >> 30) / 6;
         r  = (x * f) >> 30;
         q  = (r + 64'd16384) >> 15;
         rom[k] = (q > 64'd32767) ? 15'h7fff : q[14:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // input item, first field in the highest bits
   typedef struct packed {
      logic [31:0]        sample_time;
      logic [15:0]        heading_angle;
      logic [15:0]        roll_angle;
      logic [15:0]        pitch_angle;
      logic signed [15:0] accel_forward;
      logic signed [15:0] accel_side_raw;
   } item_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic [31:0]        elapsed_time;
      logic signed [31:0] global_accel_y;
      logic signed [31:0] global_accel_x;
      logic signed [31:0] velocity_y;
      logic signed [31:0] velocity_x;
      logic signed [31:0] position_y;
      logic signed [31:0] position_x;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SIN_P, ST_SIN_R, ST_SIN_H, ST_COS_H, ST_TILT,
      ST_MUL_GS, ST_MUL_GF, ST_MUL_SC, ST_MUL_FS, ST_MUL_SS, ST_MUL_FC,
      ST_MUL_VX, ST_ROT_GY, ST_MUL_VY, ST_MUL_PX, ST_MUL_PY, ST_FIN, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SIN_P, OP_SIN_R, OP_SIN_H, OP_COS_H, OP_TILT,
      OP_MUL_GS, OP_MUL_GF, OP_MUL_SC, OP_MUL_FS, OP_MUL_SS, OP_MUL_FC,
      OP_MUL_VX, OP_ROT_GY, OP_MUL_VY, OP_MUL_PX, OP_MUL_PY, OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   in_ready;
      logic   out_valid;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/idr_ctrl.sv @@
// sequencer for the dead reckoning datapath: one step per state
// depends on idr_pkg
`default_nettype none

module idr_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic            out_ready,
   output idr_pkg::cmd_type     cmd
);

   idr_pkg::state_type state_ff;
   idr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = idr_pkg::OP_NONE;
      cmd.in_ready  = 1'b0;
      cmd.out_valid = 1'b0;
      case (state_ff)
         idr_pkg::ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = idr_pkg::OP_LOAD;
               state_in = idr_pkg::ST_SIN_P;
            end
         end
         idr_pkg::ST_SIN_P:   begin cmd.op = idr_pkg::OP_SIN_P;   state_in = idr_pkg::ST_SIN_R;   end
         idr_pkg::ST_SIN_R:   begin cmd.op = idr_pkg::OP_SIN_R;   state_in = idr_pkg::ST_SIN_H;   end
         idr_pkg::ST_SIN_H:   begin cmd.op = idr_pkg::OP_SIN_H;   state_in = idr_pkg::ST_COS_H;   end
         idr_pkg::ST_COS_H:   begin cmd.op = idr_pkg::OP_COS_H;   state_in = idr_pkg::ST_TILT;    end
         idr_pkg::ST_TILT:    begin cmd.op = idr_pkg::OP_TILT;    state_in = idr_pkg::ST_MUL_GS;  end
         idr_pkg::ST_MUL_GS:  begin cmd.op = idr_pkg::OP_MUL_GS;  state_in = idr_pkg::ST_MUL_GF;  end
         idr_pkg::ST_MUL_GF:  begin cmd.op = idr_pkg::OP_MUL_GF;  state_in = idr_pkg::ST_MUL_SC;  end
         idr_pkg::ST_MUL_SC:  begin cmd.op = idr_pkg::OP_MUL_SC;  state_in = idr_pkg::ST_MUL_FS;  end
         idr_pkg::ST_MUL_FS:  begin cmd.op = idr_pkg::OP_MUL_FS;  state_in = idr_pkg::ST_MUL_SS;  end
         idr_pkg::ST_MUL_SS:  begin cmd.op = idr_pkg::OP_MUL_SS;  state_in = idr_pkg::ST_MUL_FC;  end
         idr_pkg::ST_MUL_FC:  begin cmd.op = idr_pkg::OP_MUL_FC;  state_in = idr_pkg::ST_MUL_VX;  end
         idr_pkg::ST_MUL_VX:  begin cmd.op = idr_pkg::OP_MUL_VX;  state_in = idr_pkg::ST_ROT_GY;  end
         idr_pkg::ST_ROT_GY:  begin cmd.op = idr_pkg::OP_ROT_GY;  state_in = idr_pkg::ST_MUL_VY;  end
         idr_pkg::ST_MUL_VY:  begin cmd.op = idr_pkg::OP_MUL_VY;  state_in = idr_pkg::ST_MUL_PX;  end
         idr_pkg::ST_MUL_PX:  begin cmd.op = idr_pkg::OP_MUL_PX;  state_in = idr_pkg::ST_MUL_PY;  end
         idr_pkg::ST_MUL_PY:  begin cmd.op = idr_pkg::OP_MUL_PY;  state_in = idr_pkg::ST_FIN;     end
         idr_pkg::ST_FIN:     begin cmd.op = idr_pkg::OP_FIN;     state_in = idr_pkg::ST_OUT;     end
         idr_pkg::ST_OUT: begin
            cmd.out_valid = 1'b1;
            if (out_ready) begin
               state_in = idr_pkg::ST_IDLE;
            end
         end
         default: state_in = idr_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/idr_datapath.sv @@
// datapath: sine lookup, one shared 33x32 multiplier, rounding, saturation, state
// depends on idr_pkg; driven step by step by idr_ctrl
`default_nettype none

module idr_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire idr_pkg::cmd_type    cmd,
   input  wire idr_pkg::item_type   item,
   input  wire logic                csr_wen,
   input  wire logic [23:0]         csr_wdata,
   output idr_pkg::result_type      result
);

   localparam int IDX_W = idr_pkg::SINE_IDX_W;
   localparam int K_W   = idr_pkg::SINE_K_W;

   function automatic logic signed [15:0] sine_of(input logic [15:0] angle);
      logic [IDX_W-1:0] idx;
      logic [1:0]       quad;
      logic [IDX_W-3:0] sub_idx;
      logic [K_W-1:0]   k;
      logic [15:0]      m;
      idx     = angle[15 -: IDX_W];
      quad    = idx[IDX_W-1 -: 2];
      sub_idx = idx[IDX_W-3:0];
      k       = quad[0] ? (K_W'(idr_pkg::SINE_QUARTER) - K_W'(sub_idx)) : K_W'(sub_idx);
      m       = {1'b0, idr_pkg::SINE_ROM[k]};
      return quad[1] ? $signed(-m) : $signed(m);
   endfunction

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7fffffff;
      if (v < -50'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // architectural state
   logic [23:0]        gravity_ff;
   logic signed [31:0] vel_x_ff, vel_y_ff, pos_x_ff, pos_y_ff;
   logic signed [31:0] last_ax_ff, last_ay_ff;
   logic [31:0]        last_time_ff;

   // working registers
   logic signed [15:0] ax_ff, ay_ff;
   logic [15:0]        pitch_ff, roll_ff, head_ff;
   logic [31:0]        now_ff, dt_ff;
   logic signed [15:0] sp_ff, sr_ff, sn_ff, cs_ff;
   logic signed [19:0] side_ff, fwd_ff;
   logic signed [31:0] a_side_ff, a_fwd_ff, gx_ff, gy_ff, vx_ff, vy_ff, px_ff;
   logic signed [47:0] acc_ff;
   logic [63:0]        prod_ff;
   logic               psign_ff;

   // shared sine lookup
   logic [15:0]        sine_angle;
   logic signed [15:0] sine_val;

   always_comb begin
      case (cmd.op)
         idr_pkg::OP_SIN_P: sine_angle = pitch_ff;
         idr_pkg::OP_SIN_R: sine_angle = roll_ff;
         idr_pkg::OP_COS_H: sine_angle = head_ff + 16'd16384;
         default:           sine_angle = head_ff;
      endcase
   end
   assign sine_val = sine_of(sine_angle);

   // shared multiplier, sign and magnitude
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic               mul_s;
   logic               mul_en;
   logic [64:0]        mul_p;
   logic signed [32:0] vsum_a;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_s  = 1'b0;
      mul_en = 1'b1;
      vsum_a = '0;
      case (cmd.op)
         idr_pkg::OP_MUL_GS: begin
            mul_a = mag33(33'(side_ff)); mul_b = 32'(gravity_ff); mul_s = side_ff[19];
         end
         idr_pkg::OP_MUL_GF: begin
            mul_a = mag33(33'(fwd_ff)); mul_b = 32'(gravity_ff); mul_s = fwd_ff[19];
         end
         idr_pkg::OP_MUL_SC: begin
            mul_a = mag33(33'(a_side_ff)); mul_b = 32'(mag33(33'(cs_ff)));
            mul_s = a_side_ff[31] ^ cs_ff[15];
         end
         idr_pkg::OP_MUL_FS: begin
            mul_a = mag33(33'(a_fwd_ff)); mul_b = 32'(mag33(33'(sn_ff)));
            mul_s = a_fwd_ff[31] ^ sn_ff[15];
         end
         idr_pkg::OP_MUL_SS: begin
            mul_a = mag33(33'(a_side_ff)); mul_b = 32'(mag33(33'(sn_ff)));
            mul_s = a_side_ff[31] ^ sn_ff[15];
         end
         idr_pkg::OP_MUL_FC: begin
            mul_a = mag33(33'(a_fwd_ff)); mul_b = 32'(mag33(33'(cs_ff)));
            mul_s = a_fwd_ff[31] ^ cs_ff[15];
         end
         idr_pkg::OP_MUL_VX: vsum_a = 33'(gx_ff) + 33'(last_ax_ff);
         idr_pkg::OP_MUL_VY: vsum_a = 33'(gy_ff) + 33'(last_ay_ff);
         idr_pkg::OP_MUL_PX: vsum_a = 33'(vx_ff) + 33'(vel_x_ff);
         idr_pkg::OP_MUL_PY: vsum_a = 33'(vy_ff) + 33'(vel_y_ff);
         default: mul_en = 1'b0;
      endcase
      if (cmd.op == idr_pkg::OP_MUL_VX || cmd.op == idr_pkg::OP_MUL_VY ||
          cmd.op == idr_pkg::OP_MUL_PX || cmd.op == idr_pkg::OP_MUL_PY) begin
         mul_a = mag33(vsum_a);
         mul_b = dt_ff;
         mul_s = vsum_a[32];
      end
   end
   assign mul_p = mul_a * mul_b;

   // rounding of the registered product, half away from zero
   logic [64:0]        t15, t17;
   logic signed [31:0] rnd15;
   logic signed [49:0] rnd17;
   logic [47:0]        prod_m;
   logic signed [47:0] sprod;
   logic [47:0]        acc_m, acc_q;
   logic signed [31:0] acc_rnd;
   logic signed [49:0] base_v;
   logic signed [31:0] integ;

   always_comb begin
      t15    = {1'b0, prod_ff} + 65'd16384;
      rnd15  = psign_ff ? -t15[46:15] : t15[46:15];
      t17    = {1'b0, prod_ff} + 65'd65536;
      rnd17  = psign_ff ? -{2'b00, t17[64:17]} : {2'b00, t17[64:17]};
      prod_m = {1'b0, prod_ff[46:0]};
      sprod  = psign_ff ? -prod_m : prod_m;
      acc_m  = acc_ff[47] ? -acc_ff : acc_ff;
      acc_q  = (acc_m + 48'd16384) >> 15;
      acc_rnd = acc_ff[47] ? -acc_q[31:0] : acc_q[31:0];
      case (cmd.op)
         idr_pkg::OP_MUL_VY: base_v = 50'(vel_x_ff);
         idr_pkg::OP_MUL_PX: base_v = 50'(vel_y_ff);
         idr_pkg::OP_MUL_PY: base_v = 50'(pos_x_ff);
         default:            base_v = 50'(pos_y_ff);
      endcase
      integ = sat32(base_v + rnd17);
   end

   // control state: configuration and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= idr_pkg::GRAVITY_RESET;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         last_ax_ff   <= '0;
         last_ay_ff   <= '0;
         last_time_ff <= '0;
      end else begin
         if (csr_wen) begin
            gravity_ff <= csr_wdata;
         end
         if (cmd.op == idr_pkg::OP_FIN) begin
            vel_x_ff     <= vx_ff;
            vel_y_ff     <= vy_ff;
            pos_x_ff     <= px_ff;
            pos_y_ff     <= integ;
            last_ax_ff   <= gx_ff;
            last_ay_ff   <= gy_ff;
            last_time_ff <= now_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff  <= mul_p[63:0];
         psign_ff <= mul_s;
      end
      case (cmd.op)
         idr_pkg::OP_LOAD: begin
            ax_ff    <= item.accel_side_raw;
            ay_ff    <= item.accel_forward;
            pitch_ff <= item.pitch_angle;
            roll_ff  <= item.roll_angle;
            head_ff  <= item.heading_angle;
            now_ff   <= item.sample_time;
            dt_ff    <= item.sample_time - last_time_ff;
         end
         idr_pkg::OP_SIN_P: sp_ff <= sine_val;
         idr_pkg::OP_SIN_R: sr_ff <= sine_val;
         idr_pkg::OP_SIN_H: sn_ff <= sine_val;
         idr_pkg::OP_COS_H: cs_ff <= sine_val;
         idr_pkg::OP_TILT: begin
            side_ff <= -{ax_ff[15], ax_ff, 3'b000} + 20'(sp_ff);
            fwd_ff  <= {ay_ff[15], ay_ff, 3'b000} + 20'(sr_ff);
         end
         idr_pkg::OP_MUL_GF: a_side_ff <= rnd15;
         idr_pkg::OP_MUL_SC: a_fwd_ff  <= rnd15;
         idr_pkg::OP_MUL_FS: acc_ff    <= sprod;
         idr_pkg::OP_MUL_SS: acc_ff    <= acc_ff + sprod;
         idr_pkg::OP_MUL_FC: begin
            gx_ff  <= acc_rnd;
            acc_ff <= sprod;
         end
         idr_pkg::OP_MUL_VX: acc_ff <= acc_ff - sprod;
         idr_pkg::OP_ROT_GY: gy_ff  <= acc_rnd;
         idr_pkg::OP_MUL_VY: vx_ff  <= integ;
         idr_pkg::OP_MUL_PX: vy_ff  <= integ;
         idr_pkg::OP_MUL_PY: px_ff  <= integ;
         default: ;
      endcase
   end

   assign result.position_x     = pos_x_ff;
   assign result.position_y     = pos_y_ff;
   assign result.velocity_x     = vel_x_ff;
   assign result.velocity_y     = vel_y_ff;
   assign result.global_accel_x = last_ax_ff;
   assign result.global_accel_y = last_ay_ff;
   assign result.elapsed_time   = dt_ff;

endmodule

`default_nettype wire

@@ rtl/inertial_dead_reckoning.sv @@
// top level of the strapdown dead reckoning block
// depends on idr_pkg, idr_ctrl and idr_datapath
`default_nettype none

// Strapdown dead reckoning over one imu sample per transaction. Each sample
// is tilt compensated, scaled by gravity, rotated by heading into global axes
// and integrated twice with the trapezoid rule over the time since the last
// sample; position and velocity saturate at 32 bits. One sample is handled
// at a time: a new sample is taken only after the result has been shown
// and accepted on rsp_tready. The pace is set by the single shared 33x32
// multiplier, which carries ten products in turn, and by four sine lookups
// through one quarter-wave rom. After reset the accumulators and last
// timestamp are zero, so the first elapsed_time is the raw timestamp.
// gravity_scale may be written through csr_wen at any idle time; it resets
// to 642689 (9.80665).

module inertial_dead_reckoning (
   input  wire logic          clock,
   input  wire logic          reset,
   // sample channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // accel_side_raw, accel_forward, pitch_angle, roll_angle, heading_angle, sample_time
   input  wire logic [111:0]  req_tdata,
   // result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // position_x, position_y, velocity_x, velocity_y, global_accel_x,
   // global_accel_y, elapsed_time
   output logic [223:0]       rsp_tdata,
   // gravity_scale register
   input  wire logic          csr_wen,
   input  wire logic [23:0]   csr_wdata
);

   idr_pkg::cmd_type    cmd;
   idr_pkg::item_type   item;
   idr_pkg::result_type result;

   assign item = idr_pkg::item_type'(req_tdata);

   // sequencer: one state per datapath step
   idr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd)
   );

   // arithmetic and state
   idr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .item      (item),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   // result registers are the committed state, held until the transaction
   assign req_tready = cmd.in_ready;
   assign rsp_tvalid = cmd.out_valid;
   assign rsp_tdata  = result;

endmodule

`default_nettype wire

@@ rtl/idr_checker.sv @@
// port level checks for inertial_dead_reckoning, bound to the top level
// depends on nothing but the top level's ports
`default_nettype none

module idr_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_tvalid,
   input wire logic          req_tready,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [223:0]  rsp_tdata
);

   // one sample in flight: no intake while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("sample taken while result pending");

   // after a sample is taken the block is busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !rsp_tvalid))
      else $error("not busy after sample accepted");

   // reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result or busy after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind inertial_dead_reckoning idr_checker u_idr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/sv/tb_inertial_dead_reckoning.sv @@
// self-checking testbench for the inertial dead reckoning block
// depends on idr_pkg and the rtl under rtl; drives samples, checks results in order
`default_nettype none

module tb_inertial_dead_reckoning;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1550;
   localparam int BLOCK_LAT    = 40;
   localparam longint CYCLE_LIMIT = 64'd2000000;
   localparam logic [23:0] GRAVITY_MAX = 24'hffffff;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [111:0]  req_tdata;    // accel_side_raw, accel_forward, pitch, roll, heading, sample_time
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [223:0]  rsp_tdata;    // pos_x, pos_y, vel_x, vel_y, accel_x, accel_y, elapsed_time
   logic          csr_wen;
   logic [23:0]   csr_wdata;

   inertial_dead_reckoning u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // predictor state: a private copy of the integrators and the gravity register
   logic [23:0]        nav_gravity;
   logic signed [31:0] nav_vel_x, nav_vel_y, nav_pos_x, nav_pos_y;
   logic signed [31:0] nav_acc_x, nav_acc_y;
   logic [31:0]        nav_last_time;

   idr_pkg::result_type expected_results[$];
   int     mismatch_count;
   bit     hold_rsp;        // long receiver hold-off requested by the sender
   longint cycle_count;

   // directed rows: a sample, with a typed expectation where obvious
   typedef struct {
      idr_pkg::item_type   sample;
      bit                  has_fixed;
      idr_pkg::result_type fixed;
   } directed_row_type;

   function automatic longint signed sine_of(logic [15:0] angle);
      longint unsigned idx, turn, frac, x, x2, f, r, q;
      int unsigned quad;
      idx  = (longint'(angle) * idr_pkg::SINE_TABLE_DEPTH) >> 16;
      turn = (idx << 32) / idr_pkg::SINE_TABLE_DEPTH;
      quad = 32'((turn >> 30) & 3);
      frac = turn & (idr_pkg::ONE_Q30 - 1);
      if (quad & 1) frac = idr_pkg::ONE_Q30 - frac;
      x  = (frac * idr_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      f  = idr_pkg::ONE_Q30 - x2 / 110;
      f  = idr_pkg::ONE_Q30 - ((x2 * f) >> 30) / 72;
      f  = idr_pkg::ONE_Q30 - ((x2 * f) >> 30) / 42;
      f  = idr_pkg::ONE_Q30 - ((x2 * f) >> 30) / 20;
      f  = idr_pkg::ONE_Q30 - ((x2 * f) >> 30) / 6;
      r  = (x * f) >> 30;
      q  = (r + 16384) >> 15;
      if (q > 32767) q = 32767;
      return (quad >= 2) ? -longint'(q) : longint'(q);
   endfunction

   // sign times round-half-away of |a|*b >> s
   function automatic longint signed scale_round(longint signed a, longint unsigned b, int s);
      longint unsigned mag, q;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      q   = (mag * b + (64'd1 << (s - 1))) >> s;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [31:0] clamp32(longint signed v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic idr_pkg::result_type navigate(idr_pkg::item_type s);
      idr_pkg::result_type res;
      longint signed side, fwd, a_side, a_fwd, sn, cs, gx, gy;
      logic [31:0] dt;
      logic signed [31:0] vx, vy, px, py;
      side   = -longint'(s.accel_side_raw) * 8 + sine_of(s.pitch_angle);
      fwd    = longint'(s.accel_forward) * 8 + sine_of(s.roll_angle);
      a_side = scale_round(side, nav_gravity, 15);
      a_fwd  = scale_round(fwd, nav_gravity, 15);
      sn     = sine_of(s.heading_angle);
      cs     = sine_of(s.heading_angle + 16'd16384);
      gx     = scale_round(a_side * cs + a_fwd * sn, 1, 15);
      gy     = scale_round(a_side * sn - a_fwd * cs, 1, 15);
      dt     = s.sample_time - nav_last_time;
      vx = clamp32(longint'(nav_vel_x) + scale_round(gx + nav_acc_x, dt, 17));
      vy = clamp32(longint'(nav_vel_y) + scale_round(gy + nav_acc_y, dt, 17));
      px = clamp32(longint'(nav_pos_x) + scale_round(longint'(vx) + nav_vel_x, dt, 17));
      py = clamp32(longint'(nav_pos_y) + scale_round(longint'(vy) + nav_vel_y, dt, 17));
      nav_vel_x = vx; nav_vel_y = vy; nav_pos_x = px; nav_pos_y = py;
      nav_acc_x = gx[31:0]; nav_acc_y = gy[31:0];
      nav_last_time = s.sample_time;
      res.position_x = px; res.position_y = py;
      res.velocity_x = vx; res.velocity_y = vy;
      res.global_accel_x = gx[31:0]; res.global_accel_y = gy[31:0];
      res.elapsed_time = dt;
      return res;
   endfunction

   // clock generator
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** inertial_dead_reckoning: FAILED **");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // result side: random back-pressure, long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0 && $urandom_range(0, 3) != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      idr_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: pos %0d/%0d exp %0d/%0d, vel %0d/%0d exp %0d/%0d, %s",
                     got.position_x, got.position_y, want.position_x, want.position_y,
                     got.velocity_x, got.velocity_y, want.velocity_x, want.velocity_y,
                     $sformatf("acc %0d/%0d exp %0d/%0d, dt %0d exp %0d",
                        got.global_accel_x, got.global_accel_y,
                        want.global_accel_x, want.global_accel_y,
                        got.elapsed_time, want.elapsed_time));
            end
         end
      end
   end

   // offer one sample and wait for its transaction; prediction at acceptance
   task automatic send_sample(idr_pkg::item_type s, bit has_fixed, idr_pkg::result_type fixed);
      idr_pkg::result_type predicted;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = navigate(s);
      if (has_fixed && predicted !== fixed) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("hand value disagrees with prediction for sample %h", s);
      end
      expected_results.push_back(predicted);
      @(negedge clock);
   endtask

   // write gravity only once the block has drained
   task automatic set_gravity(logic [23:0] value);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (BLOCK_LAT) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      nav_gravity = value;
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'(16'h4000 * $urandom_range(0, 3));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic idr_pkg::item_type random_sample(logic [31:0] prev_time);
      idr_pkg::item_type s;
      s.accel_side_raw = ($urandom_range(0, 9) == 0) ? 16'h8000 : 16'($urandom());
      s.accel_forward  = ($urandom_range(0, 9) == 0) ? 16'h7fff : 16'($urandom());
      s.pitch_angle    = pick_angle();
      s.roll_angle     = pick_angle();
      s.heading_angle  = pick_angle();
      // mostly realistic gaps, sometimes a zero, huge or wrapping one
      case ($urandom_range(0, 9))
         0: s.sample_time = $urandom();
         1: s.sample_time = prev_time;
         default: s.sample_time = prev_time + $urandom_range(1, 2000);
      endcase
      return s;
   endfunction

   // stimulus
   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      idr_pkg::result_type zero_res;
      idr_pkg::item_type s;
      logic [31:0] t;
      logic [23:0] gravity_plan[4];

      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      csr_wen = 1'b0; csr_wdata = '0;
      mismatch_count = 0; hold_rsp = 0;
      nav_gravity = idr_pkg::GRAVITY_RESET;
      nav_vel_x = 0; nav_vel_y = 0; nav_pos_x = 0; nav_pos_y = 0;
      nav_acc_x = 0; nav_acc_y = 0; nav_last_time = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      zero_res = '0;
      // level and still at time zero after reset: nothing moves
      row.sample = '0; row.has_fixed = 1; row.fixed = zero_res; rows.push_back(row);
      // same timestamp again: zero elapsed time
      row.sample = '0; row.sample.accel_forward = 16'sh7fff; row.has_fixed = 0;
      rows.push_back(row);
      row.sample = '0; row.sample.accel_side_raw = 16'sh8000; row.sample.sample_time = 32'd1;
      rows.push_back(row);
      row.sample = '1; rows.push_back(row);
      row.sample = '0; row.sample.pitch_angle = 16'h4000; row.sample.roll_angle = 16'hc000;
      row.sample.heading_angle = 16'h8000; row.sample.sample_time = 32'd65536;
      rows.push_back(row);
      row.sample.heading_angle = 16'h4000; row.sample.sample_time = 32'd131072;
      rows.push_back(row);
      // huge gap: integrators saturate
      row.sample = '0; row.sample.accel_forward = 16'sh7fff; row.sample.accel_side_raw = 16'sh7fff;
      row.sample.sample_time = 32'hfffffff0; rows.push_back(row);
      row.sample.sample_time = 32'h0000fff0; rows.push_back(row);
      row.sample.accel_forward = 16'sh8000; row.sample.accel_side_raw = 16'sh8000;
      row.sample.sample_time = 32'h7fff0000; rows.push_back(row);
      row.sample.sample_time = 32'hffffffff; rows.push_back(row);
      row.sample = 112'haaaa_5555_aaaa_5555_aaaa_5555_aaaa; rows.push_back(row);
      row.sample = 112'h5555_aaaa_5555_aaaa_5555_aaaa_5555; rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].sample, rows[i].has_fixed, rows[i].fixed);

      // gravity extremes, then random phases
      gravity_plan[0] = 24'd0;
      gravity_plan[1] = GRAVITY_MAX;
      gravity_plan[2] = 24'($urandom());
      gravity_plan[3] = idr_pkg::GRAVITY_RESET;
      t = nav_last_time;
      for (int phase = 0; phase < 4; phase++) begin
         set_gravity(gravity_plan[phase]);
         if (phase < 2) begin
            for (int k = 0; k < 6; k++) begin
               s = random_sample(t);
               t = s.sample_time;
               send_sample(s, 0, zero_res);
            end
         end else begin
            for (int k = 0; k < RANDOM_ITEMS / 2; k++) begin
               if (phase == 2 && k == 100) hold_rsp = 1'b1;
               s = random_sample(t);
               t = s.sample_time;
               // a stretch without sender gaps now and then
               if (k % 200 < 30) begin
                  req_tvalid <= 1'b1;
                  req_tdata  <= s;
                  @(posedge clock);
                  while (!req_tready) @(posedge clock);
                  expected_results.push_back(navigate(s));
                  @(negedge clock);
               end else
                  send_sample(s, 0, zero_res);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(negedge clock);
      repeat (BLOCK_LAT) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("** inertial_dead_reckoning: PASSED **");
      else
         $display("** inertial_dead_reckoning: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
